>>> hdl/wmrc_pkg.sv
// ---------------------------------------------------------------------------
// wmrc_pkg: shared types, constants and rate tables
// Class, code rate and status codes, the divider selection, the VHT/HT
// per-stream rate table and the HE per-stream rate table.
// ---------------------------------------------------------------------------
package wmrc_pkg;

   localparam int RATE_W = 33;   // data and PHY rate width
   localparam int REF_W  = 26;   // non-HT reference rate width
   localparam int PS_W   = 31;   // per-stream base rate width
   localparam int BITS_W = 4;    // bits per subcarrier width
   localparam int DEN_W  = 3;    // code rate denominator width

   localparam int HI_W = 18;     // upper half of the scaled rate
   localparam int LO_W = 18;     // lower half of the scaled rate
   localparam int Y_W  = 21;     // remainder joined with the lower half

   localparam int VHT_ENTRIES = 80;
   localparam int HE_ROWS     = 7;
   localparam int HE_MCS      = 12;

   // Multiply-and-shift reciprocals for exact floor division by 3 and 5
   localparam logic [HI_W-1:0] RECIP3_HI = 18'd174763;   // shift 19
   localparam logic [HI_W-1:0] RECIP5_HI = 18'd209716;   // shift 20
   localparam logic [21:0]     RECIP3_LO = 22'd2796203;  // shift 23
   localparam logic [21:0]     RECIP5_LO = 22'd3355444;  // shift 24

   localparam logic [PS_W-1:0] DSSS_PER_BIT    = 31'd1000000;
   localparam logic [PS_W-1:0] HR_DSSS_PER_BIT = 31'd1375000;

   typedef enum logic [2:0] {
      CLS_DSSS, CLS_HR_DSSS, CLS_OFDM, CLS_ERP_OFDM, CLS_HT, CLS_VHT, CLS_HE
   } class_type;

   typedef enum logic [2:0] {
      CR_UNDEF, CR_1_2, CR_2_3, CR_3_4, CR_5_6
   } code_rate_type;

   typedef enum logic [1:0] {
      DIV_1, DIV_2, DIV_3, DIV_5
   } div_type;

   typedef enum logic [1:0] {
      ST_OK, ST_BAD_RATE, ST_NO_ENTRY, ST_BAD_CLASS
   } status_type;

   typedef struct packed {
      logic [REF_W-1:0] ref_rate;
      logic             ref_valid;
      status_type       status;
   } side_type;

   typedef logic [PS_W-1:0] vht_rom_type [VHT_ENTRIES];
   typedef logic [PS_W-1:0] he_rom_type [HE_ROWS][HE_MCS];

   function automatic code_rate_type mcs_code_rate(input logic [3:0] m);
      code_rate_type cr;
      case (m)
         4'd0, 4'd1, 4'd3:                cr = CR_1_2;
         4'd5:                            cr = CR_2_3;
         4'd2, 4'd4, 4'd6, 4'd8, 4'd10:   cr = CR_3_4;
         4'd7, 4'd9, 4'd11:               cr = CR_5_6;
         default:                         cr = CR_UNDEF;
      endcase
      return cr;
   endfunction

   function automatic logic [BITS_W-1:0] mcs_bits(input logic [3:0] m);
      logic [BITS_W-1:0] b;
      case (m)
         4'd0:               b = 4'd1;
         4'd1, 4'd2:         b = 4'd2;
         4'd3, 4'd4:         b = 4'd4;
         4'd5, 4'd6, 4'd7:   b = 4'd6;
         4'd8, 4'd9:         b = 4'd8;
         4'd10, 4'd11:       b = 4'd10;
         default:            b = 4'd0;
      endcase
      return b;
   endfunction

   function automatic logic [DEN_W-1:0] cr_num(input code_rate_type cr);
      logic [DEN_W-1:0] n;
      case (cr)
         CR_1_2:  n = 3'd1;
         CR_2_3:  n = 3'd2;
         CR_3_4:  n = 3'd3;
         CR_5_6:  n = 3'd5;
         default: n = 3'd0;
      endcase
      return n;
   endfunction

   function automatic logic [DEN_W-1:0] cr_den(input code_rate_type cr);
      logic [DEN_W-1:0] d;
      case (cr)
         CR_1_2:  d = 3'd2;
         CR_2_3:  d = 3'd3;
         CR_3_4:  d = 3'd4;
         CR_5_6:  d = 3'd6;
         default: d = 3'd1;
      endcase
      return d;
   endfunction

   function automatic div_type cr_div(input code_rate_type cr);
      div_type dv;
      case (cr)
         CR_2_3:  dv = DIV_2;
         CR_3_4:  dv = DIV_3;
         CR_5_6:  dv = DIV_5;
         default: dv = DIV_1;
      endcase
      return dv;
   endfunction

   // OFDM rate per coded bit at 20 MHz (48 subcarriers, 4 us symbol)
   function automatic logic [PS_W-1:0] ofdm_per_bit(input code_rate_type cr);
      logic [PS_W-1:0] k;
      case (cr)
         CR_1_2:  k = 31'd6000000;
         CR_2_3:  k = 31'd8000000;
         CR_3_4:  k = 31'd9000000;
         default: k = '0;
      endcase
      return k;
   endfunction

   function automatic logic [REF_W-1:0] ref_rate(input logic [BITS_W-1:0] bits,
                                                 input code_rate_type cr);
      logic [REF_W-1:0] r;
      case (bits)
         4'd1:    r = (cr == CR_1_2) ? 26'd6000000  : 26'd9000000;
         4'd2:    r = (cr == CR_1_2) ? 26'd12000000 : 26'd18000000;
         4'd4:    r = (cr == CR_1_2) ? 26'd24000000 : 26'd36000000;
         4'd6:    r = (cr == CR_1_2 || cr == CR_2_3) ? 26'd48000000 : 26'd54000000;
         default: r = 26'd54000000;
      endcase
      return r;
   endfunction

   // Index of the highest set bit; 0 and 1 give 0
   function automatic logic [BITS_W-1:0] floor_log2(input logic [8:0] v);
      logic [BITS_W-1:0] n;
      n = '0;
      for (int i = 1; i < 9; i++) begin
         if (v[i]) n = BITS_W'(i);
      end
      return n;
   endfunction

   // Exact ceiling of subcarriers * bits * code rate * symbol rate
   function automatic vht_rom_type build_vht_rom();
      vht_rom_type   rom;
      longint        nsc;
      longint        num;
      longint        r;
      code_rate_type cr;
      for (int m = 0; m < 10; m++) begin
         for (int n = 0; n < 4; n++) begin
            for (int s = 0; s < 2; s++) begin
               case (n)
                  1:       nsc = 108;
                  2:       nsc = 234;
                  3:       nsc = 468;
                  default: nsc = 52;
               endcase
               cr  = mcs_code_rate(4'(m));
               num = nsc * longint'(mcs_bits(4'(m))) * longint'(cr_num(cr));
               case (cr)
                  CR_1_2:  r = (s != 0) ? (num * 10000000 + 71) / 72
                                        : (num * 250000 + 1) / 2;
                  CR_2_3:  r = (s != 0) ? (num * 10000000 + 107) / 108
                                        : (num * 250000 + 2) / 3;
                  CR_3_4:  r = (s != 0) ? (num * 10000000 + 143) / 144
                                        : (num * 250000 + 3) / 4;
                  CR_5_6:  r = (s != 0) ? (num * 10000000 + 215) / 216
                                        : (num * 250000 + 5) / 6;
                  default: r = 0;
               endcase
               rom[m * 8 + n * 2 + s] = PS_W'(r);
            end
         end
      end
      return rom;
   endfunction

   localparam vht_rom_type VHT_ROM = build_vht_rom();

   // Rows: 26, 52, 106, 242, 484, 996 and 2x996 tones; zero marks no entry
   localparam he_rom_type HE_ROM = '{
      '{31'd900000, 31'd1800000, 31'd2600000, 31'd3500000, 31'd5300000,
        31'd7100000, 31'd7900000, 31'd8800000, 31'd10600000, 31'd11800000,
        31'd0, 31'd0},
      '{31'd1800000, 31'd3500000, 31'd5300000, 31'd7100000, 31'd10600000,
        31'd14100000, 31'd15900000, 31'd17600000, 31'd21200000, 31'd23500000,
        31'd0, 31'd0},
      '{31'd3800000, 31'd7500000, 31'd11300000, 31'd15000000, 31'd22500000,
        31'd30000000, 31'd33800000, 31'd37500000, 31'd45000000, 31'd50000000,
        31'd0, 31'd0},
      '{31'd8600000, 31'd17200000, 31'd25800000, 31'd34400000, 31'd51600000,
        31'd68800000, 31'd77400000, 31'd86000000, 31'd103200000, 31'd114700000,
        31'd129000000, 31'd143400000},
      '{31'd17200000, 31'd34400000, 31'd51600000, 31'd68800000, 31'd103200000,
        31'd137600000, 31'd154900000, 31'd172100000, 31'd206500000, 31'd229400000,
        31'd258100000, 31'd286800000},
      '{31'd36000000, 31'd72100000, 31'd108100000, 31'd144100000, 31'd216200000,
        31'd288200000, 31'd324300000, 31'd360300000, 31'd432400000, 31'd480400000,
        31'd540400000, 31'd600400000},
      '{31'd72100000, 31'd144100000, 31'd216200000, 31'd288200000, 31'd432400000,
        31'd576500000, 31'd648500000, 31'd720600000, 31'd864700000, 31'd960700000,
        31'd1080900000, 31'd1201000000}
   };

   function automatic logic [PS_W-1:0] he_rate(input logic [2:0] row,
                                               input logic [3:0] mcs);
      logic [PS_W-1:0] r;
      r = '0;
      if (row < 3'd7 && mcs < 4'd12) r = HE_ROM[row][mcs];
      return r;
   endfunction

endpackage

>>> hdl/wifi_mcs_rate_calculator_top.sv
// ---------------------------------------------------------------------------
// wifi_mcs_rate_calculator_top: 802.11 data, PHY and reference rate lookup
// Six-stage pipeline from one rate request to one rate result.
// ---------------------------------------------------------------------------
// Usage:
//   req_* carries one rate request per item: modulation class in tuser, the
//   MCS, legacy code rate and constellation, width code, guard interval and
//   stream count in tdata. rsp_* returns exactly one result per request, in
//   request order: data rate, PHY rate and reference rate in tdata, status
//   and reference valid flag in tuser.
// Depth: 6 register stages; rsp_tvalid is the valid bit of the last stage.
// Throughput: one item per cycle while rsp_tready is high; each stage holds
//   its own valid bit, so bubbles collapse and a new item enters whenever
//   the first stage is free.
// Stages: decode and table lookup, rate times the bits-and-streams factor, scale by
//   the code rate denominator, then a two-step divide by the numerator
//   (upper half, then remainder joined with the lower half).
// Reset: all valid bits clear; the pipeline comes up empty.
// Stall: when rsp_tready is low the last stage holds its item; earlier
//   stages keep filling until the pipeline is full, then req_tready drops.
// ---------------------------------------------------------------------------
module wifi_mcs_rate_calculator_top #(
   parameter int MAX_STREAMS = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [4:0] mcs_index, [7:5] legacy_code_rate, [16:8] legacy_constellation,
   // [24:17] width_code, [25] short_gi, [28:26] stream_count
   input  logic [31:0] req_tdata,
   // [2:0] mod_class
   input  logic [2:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [32:0] data_rate, [65:33] phy_rate, [91:66] reference_rate
   output logic [95:0] rsp_tdata,
   // [1:0] status, [2] reference_valid
   output logic [2:0]  rsp_tuser
);

   localparam int NSS_W  = $clog2(MAX_STREAMS + 1);
   localparam int F_W    = wmrc_pkg::BITS_W + NSS_W;
   localparam int PROD_W = wmrc_pkg::PS_W + F_W;
   localparam int X_W    = wmrc_pkg::HI_W + wmrc_pkg::LO_W;

   // ---------------- request fields
   wmrc_pkg::class_type cls;
   logic [4:0]          mcs;
   logic [2:0]          lcr_raw;
   logic [8:0]          lcon;
   logic [7:0]          width;
   logic                sgi;
   logic [2:0]          nss_raw;

   assign cls     = wmrc_pkg::class_type'(req_tuser);
   assign mcs     = req_tdata[4:0];
   assign lcr_raw = req_tdata[7:5];
   assign lcon    = req_tdata[16:8];
   assign width   = req_tdata[24:17];
   assign sgi     = req_tdata[25];
   assign nss_raw = req_tdata[28:26];

   // ---------------- stage enables
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, s5_valid_ff, s6_valid_ff;
   logic en1, en2, en3, en4, en5, en6;

   assign en6 = !s6_valid_ff || rsp_tready;
   assign en5 = !s5_valid_ff || en6;
   assign en4 = !s4_valid_ff || en5;
   assign en3 = !s3_valid_ff || en4;
   assign en2 = !s2_valid_ff || en3;
   assign en1 = !s1_valid_ff || en2;
   assign req_tready = en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
         s6_valid_ff <= 1'b0;
      end else begin
         if (en1) s1_valid_ff <= req_tvalid;
         if (en2) s2_valid_ff <= s1_valid_ff;
         if (en3) s3_valid_ff <= s2_valid_ff;
         if (en4) s4_valid_ff <= s3_valid_ff;
         if (en5) s5_valid_ff <= s4_valid_ff;
         if (en6) s6_valid_ff <= s5_valid_ff;
      end
   end

   // ---------------- stage 1: decode and table lookup
   wmrc_pkg::code_rate_type     lcr;
   wmrc_pkg::code_rate_type     cr;
   logic [wmrc_pkg::BITS_W-1:0] bits_leg;
   logic [wmrc_pkg::BITS_W-1:0] bits_mul;
   logic [NSS_W-1:0]            nss_sat;
   logic [3:0]                  nss_ext;
   logic [4:0]                  m_vht;
   logic [1:0]                  nsc_sel;
   logic [1:0]                  sym_shift;
   logic [2:0]                  he_row;
   logic                        he_row_ok;
   logic [wmrc_pkg::PS_W-1:0]   he_val;
   logic [wmrc_pkg::PS_W-1:0]   s1_rate_in;
   logic [F_W-1:0]              s1_factor_in;
   wmrc_pkg::side_type          s1_side_in;

   logic [wmrc_pkg::PS_W-1:0]   s1_rate_ff;
   logic [F_W-1:0]              s1_factor_ff;
   wmrc_pkg::div_type           s1_div_ff;
   logic [wmrc_pkg::DEN_W-1:0]  s1_den_ff;
   wmrc_pkg::side_type          s1_side_ff;

   always_comb begin
      lcr = (lcr_raw > 3'd4) ? wmrc_pkg::CR_UNDEF : wmrc_pkg::code_rate_type'(lcr_raw);
      bits_leg = wmrc_pkg::floor_log2(lcon);
      nss_ext = {1'b0, nss_raw};
      nss_sat = (nss_ext > 4'(MAX_STREAMS)) ? NSS_W'(MAX_STREAMS) : NSS_W'(nss_ext);
      m_vht = (cls == wmrc_pkg::CLS_HT) ? {2'b00, mcs[2:0]} : mcs;

      case (width)
         8'd40:   nsc_sel = 2'd1;
         8'd80:   nsc_sel = 2'd2;
         8'd160:  nsc_sel = 2'd3;
         default: nsc_sel = 2'd0;
      endcase

      case (width)
         8'd10:   sym_shift = 2'd1;
         8'd5:    sym_shift = 2'd2;
         default: sym_shift = 2'd0;
      endcase

      he_row_ok = 1'b1;
      case (width)
         8'd2:    he_row = 3'd0;
         8'd4:    he_row = 3'd1;
         8'd8:    he_row = 3'd2;
         8'd20:   he_row = 3'd3;
         8'd40:   he_row = 3'd4;
         8'd80:   he_row = 3'd5;
         8'd160:  he_row = 3'd6;
         default: begin
            he_row    = 3'd7;
            he_row_ok = 1'b0;
         end
      endcase
      he_val = wmrc_pkg::he_rate(he_row, mcs[3:0]);

      s1_rate_in = '0;
      bits_mul   = 4'd1;
      cr         = wmrc_pkg::CR_UNDEF;
      s1_side_in = '{ref_rate: '0, ref_valid: 1'b0, status: wmrc_pkg::ST_OK};

      case (cls)
         wmrc_pkg::CLS_DSSS, wmrc_pkg::CLS_HR_DSSS: begin
            s1_rate_in = (cls == wmrc_pkg::CLS_DSSS) ? wmrc_pkg::DSSS_PER_BIT
                                                     : wmrc_pkg::HR_DSSS_PER_BIT;
            bits_mul = bits_leg;
            cr       = lcr;
         end
         wmrc_pkg::CLS_OFDM, wmrc_pkg::CLS_ERP_OFDM: begin
            if (lcr == wmrc_pkg::CR_UNDEF || lcr == wmrc_pkg::CR_5_6) begin
               s1_side_in.status = wmrc_pkg::ST_BAD_RATE;
            end else begin
               s1_rate_in = wmrc_pkg::ofdm_per_bit(lcr) >> sym_shift;
               bits_mul   = bits_leg;
               cr         = lcr;
            end
         end
         wmrc_pkg::CLS_HT, wmrc_pkg::CLS_VHT: begin
            if (m_vht > 5'd9) begin
               s1_side_in.status = wmrc_pkg::ST_BAD_RATE;
            end else begin
               s1_rate_in = wmrc_pkg::VHT_ROM[{m_vht[3:0], nsc_sel, sgi}];
               cr         = wmrc_pkg::mcs_code_rate(m_vht[3:0]);
               s1_side_in.ref_rate  = wmrc_pkg::ref_rate(wmrc_pkg::mcs_bits(m_vht[3:0]), cr);
               s1_side_in.ref_valid = 1'b1;
            end
         end
         wmrc_pkg::CLS_HE: begin
            if (mcs > 5'd11) begin
               s1_side_in.status = wmrc_pkg::ST_BAD_RATE;
            end else if (!he_row_ok || he_val == '0) begin
               s1_side_in.status = wmrc_pkg::ST_NO_ENTRY;
            end else begin
               s1_rate_in = he_val;
               cr         = wmrc_pkg::mcs_code_rate(mcs[3:0]);
            end
         end
         default: begin
            s1_side_in.status = wmrc_pkg::ST_BAD_CLASS;
         end
      endcase

      s1_factor_in = F_W'(bits_mul) * F_W'(nss_sat);
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_rate_ff   <= s1_rate_in;
         s1_factor_ff <= s1_factor_in;
         s1_div_ff    <= wmrc_pkg::cr_div(cr);
         s1_den_ff    <= wmrc_pkg::cr_den(cr);
         s1_side_ff   <= s1_side_in;
      end
   end

   // ---------------- stage 2: rate times the bits-and-streams factor, wrap to 33 bits
   logic [PROD_W-1:0]           s2_prod;
   logic [wmrc_pkg::RATE_W-1:0] s2_rate_ff;
   wmrc_pkg::div_type           s2_div_ff;
   logic [wmrc_pkg::DEN_W-1:0]  s2_den_ff;
   wmrc_pkg::side_type          s2_side_ff;

   assign s2_prod = PROD_W'(s1_rate_ff) * PROD_W'(s1_factor_ff);

   always_ff @(posedge clock) begin
      if (en2) begin
         s2_rate_ff <= s2_prod[wmrc_pkg::RATE_W-1:0];
         s2_div_ff  <= s1_div_ff;
         s2_den_ff  <= s1_den_ff;
         s2_side_ff <= s1_side_ff;
      end
   end

   // ---------------- stage 3: scale by the code rate denominator
   logic [X_W-1:0]              s3_x_in;
   logic [X_W-1:0]              s3_x_ff;
   logic [wmrc_pkg::RATE_W-1:0] s3_rate_ff;
   wmrc_pkg::div_type           s3_div_ff;
   wmrc_pkg::side_type          s3_side_ff;

   assign s3_x_in = X_W'(s2_rate_ff) * X_W'(s2_den_ff);

   always_ff @(posedge clock) begin
      if (en3) begin
         s3_x_ff    <= s3_x_in;
         s3_rate_ff <= s2_rate_ff;
         s3_div_ff  <= s2_div_ff;
         s3_side_ff <= s2_side_ff;
      end
   end

   // ---------------- stage 4: divide the upper half by the numerator
   logic [wmrc_pkg::HI_W-1:0]   s4_xh;
   logic [2*wmrc_pkg::HI_W-1:0] s4_p3;
   logic [2*wmrc_pkg::HI_W-1:0] s4_p5;
   logic [wmrc_pkg::HI_W-1:0]   s4_qh_in;
   logic [wmrc_pkg::HI_W-1:0]   s4_qh_ff;
   logic [wmrc_pkg::HI_W-1:0]   s4_xh_ff;
   logic [wmrc_pkg::LO_W-1:0]   s4_xl_ff;
   logic [wmrc_pkg::RATE_W-1:0] s4_rate_ff;
   wmrc_pkg::div_type           s4_div_ff;
   wmrc_pkg::side_type          s4_side_ff;

   assign s4_xh = s3_x_ff[X_W-1:wmrc_pkg::LO_W];
   assign s4_p3 = {{wmrc_pkg::HI_W{1'b0}}, s4_xh} * {{wmrc_pkg::HI_W{1'b0}}, wmrc_pkg::RECIP3_HI};
   assign s4_p5 = {{wmrc_pkg::HI_W{1'b0}}, s4_xh} * {{wmrc_pkg::HI_W{1'b0}}, wmrc_pkg::RECIP5_HI};

   always_comb begin
      case (s3_div_ff)
         wmrc_pkg::DIV_2: s4_qh_in = {1'b0, s4_xh[wmrc_pkg::HI_W-1:1]};
         wmrc_pkg::DIV_3: s4_qh_in = {1'b0, s4_p3[35:19]};
         wmrc_pkg::DIV_5: s4_qh_in = {2'b00, s4_p5[35:20]};
         default:         s4_qh_in = s4_xh;
      endcase
   end

   always_ff @(posedge clock) begin
      if (en4) begin
         s4_qh_ff   <= s4_qh_in;
         s4_xh_ff   <= s4_xh;
         s4_xl_ff   <= s3_x_ff[wmrc_pkg::LO_W-1:0];
         s4_rate_ff <= s3_rate_ff;
         s4_div_ff  <= s3_div_ff;
         s4_side_ff <= s3_side_ff;
      end
   end

   // ---------------- stage 5: upper remainder, joined with the lower half
   logic [wmrc_pkg::HI_W-1:0]   s5_qn;
   logic [wmrc_pkg::HI_W-1:0]   s5_rem;
   logic [wmrc_pkg::Y_W-1:0]    s5_y_ff;
   logic [wmrc_pkg::HI_W-1:0]   s5_qh_ff;
   logic [wmrc_pkg::RATE_W-1:0] s5_rate_ff;
   wmrc_pkg::div_type           s5_div_ff;
   wmrc_pkg::side_type          s5_side_ff;

   always_comb begin
      case (s4_div_ff)
         wmrc_pkg::DIV_2: s5_qn = s4_qh_ff << 1;
         wmrc_pkg::DIV_3: s5_qn = (s4_qh_ff << 1) + s4_qh_ff;
         wmrc_pkg::DIV_5: s5_qn = (s4_qh_ff << 2) + s4_qh_ff;
         default:         s5_qn = s4_qh_ff;
      endcase
      s5_rem = s4_xh_ff - s5_qn;
   end

   always_ff @(posedge clock) begin
      if (en5) begin
         s5_y_ff    <= {s5_rem[2:0], s4_xl_ff};
         s5_qh_ff   <= s4_qh_ff;
         s5_rate_ff <= s4_rate_ff;
         s5_div_ff  <= s4_div_ff;
         s5_side_ff <= s4_side_ff;
      end
   end

   // ---------------- stage 6: divide the lower part, assemble the result
   logic [42:0]                 s6_p3;
   logic [42:0]                 s6_p5;
   logic [wmrc_pkg::LO_W-1:0]   s6_ql;
   logic [X_W-1:0]              s6_phy_full;
   logic [wmrc_pkg::RATE_W-1:0] s6_rate_ff;
   logic [wmrc_pkg::RATE_W-1:0] s6_phy_ff;
   wmrc_pkg::side_type          s6_side_ff;

   assign s6_p3 = {22'b0, s5_y_ff} * {21'b0, wmrc_pkg::RECIP3_LO};
   assign s6_p5 = {22'b0, s5_y_ff} * {21'b0, wmrc_pkg::RECIP5_LO};

   always_comb begin
      case (s5_div_ff)
         wmrc_pkg::DIV_2: s6_ql = s5_y_ff[wmrc_pkg::LO_W:1];
         wmrc_pkg::DIV_3: s6_ql = s6_p3[40:23];
         wmrc_pkg::DIV_5: s6_ql = s6_p5[41:24];
         default:         s6_ql = s5_y_ff[wmrc_pkg::LO_W-1:0];
      endcase
      s6_phy_full = {s5_qh_ff, s6_ql};
   end

   always_ff @(posedge clock) begin
      if (en6) begin
         s6_rate_ff <= s5_rate_ff;
         s6_phy_ff  <= s6_phy_full[wmrc_pkg::RATE_W-1:0];
         s6_side_ff <= s5_side_ff;
      end
   end

   assign rsp_tvalid = s6_valid_ff;
   assign rsp_tdata  = {4'b0000, s6_side_ff.ref_rate, s6_phy_ff, s6_rate_ff};
   assign rsp_tuser  = {s6_side_ff.ref_valid, s6_side_ff.status};

endmodule

>>> hdl/wmrc_checker.sv
// ---------------------------------------------------------------------------
// wmrc_checker: port-level checks for the rate calculator
// Watches the result channel for handshake and result consistency.
// ---------------------------------------------------------------------------
module wmrc_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [95:0] rsp_tdata,
   input logic [2:0]  rsp_tuser
);

   logic        rsp_ok;
   logic [32:0] data_rate;
   logic [32:0] phy_rate;
   logic [25:0] ref_rate;

   assign rsp_ok    = (rsp_tuser[1:0] == wmrc_pkg::ST_OK);
   assign data_rate = rsp_tdata[32:0];
   assign phy_rate  = rsp_tdata[65:33];
   assign ref_rate  = rsp_tdata[91:66];

   // Pipeline comes up empty after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // Hold a stalled item
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // An error item carries no rates
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_ok |-> data_rate == '0 && phy_rate == '0 && !rsp_tuser[2])
      else $error("error result carries a rate");

   // Reference rate is zero unless flagged
   a_ref_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[2] |-> ref_rate == '0)
      else $error("reference rate without valid flag");

   // Inverse code rate never shrinks the rate
   a_phy_ge: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_ok |-> phy_rate >= data_rate)
      else $error("PHY rate below data rate");

endmodule

bind wifi_mcs_rate_calculator_top wmrc_checker u_wmrc_checker (.*);

>>> sim/wifi_mcs_rate_calculator_checker.sv
// ---------------------------------------------------------------------------
// wifi_mcs_rate_calculator_checker: rate request/response scoreboard
// Watches both stream channels of the rate calculator. Each accepted request
// is turned into the expected data, PHY and reference rate. Each accepted
// response is compared field by field with the oldest expected rate set.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module wifi_mcs_rate_calculator_checker #(
   parameter int MAX_STREAMS = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   // [4:0] mcs_index, [7:5] legacy_code_rate, [16:8] legacy_constellation,
   // [24:17] width_code, [25] short_gi, [28:26] stream_count
   input  logic [31:0] req_tdata,
   // [2:0] mod_class
   input  logic [2:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [32:0] data_rate, [65:33] phy_rate, [91:66] reference_rate
   input  logic [95:0] rsp_tdata,
   // [1:0] status, [2] reference_valid
   input  logic [2:0]  rsp_tuser,
   output int          error_count,
   output int          pending_count,
   output int          result_count
);

   localparam longint unsigned MASK33 = 64'h1_FFFF_FFFF;

   typedef struct {
      logic [32:0]          data_rate;
      logic [32:0]          phy_rate;
      logic [25:0]          reference_rate;
      wmrc_pkg::status_type status;
      logic                 reference_valid;
   } rate_set_type;

   // Code rate and bits per subcarrier for MCS 0 to 11
   localparam wmrc_pkg::code_rate_type MCS_RATE [12] = '{
      wmrc_pkg::CR_1_2, wmrc_pkg::CR_1_2, wmrc_pkg::CR_3_4, wmrc_pkg::CR_1_2,
      wmrc_pkg::CR_3_4, wmrc_pkg::CR_2_3, wmrc_pkg::CR_3_4, wmrc_pkg::CR_5_6,
      wmrc_pkg::CR_3_4, wmrc_pkg::CR_5_6, wmrc_pkg::CR_3_4, wmrc_pkg::CR_5_6
   };
   localparam int MCS_BITS [12] = '{1, 2, 2, 4, 4, 6, 6, 6, 8, 8, 10, 10};

   // HE per-stream rates: 26, 52, 106, 242, 484, 996, 2x996 tones; 0 = none
   localparam int unsigned HE_PER_STREAM [7][12] = '{
      '{900000, 1800000, 2600000, 3500000, 5300000, 7100000,
        7900000, 8800000, 10600000, 11800000, 0, 0},
      '{1800000, 3500000, 5300000, 7100000, 10600000, 14100000,
        15900000, 17600000, 21200000, 23500000, 0, 0},
      '{3800000, 7500000, 11300000, 15000000, 22500000, 30000000,
        33800000, 37500000, 45000000, 50000000, 0, 0},
      '{8600000, 17200000, 25800000, 34400000, 51600000, 68800000,
        77400000, 86000000, 103200000, 114700000, 129000000, 143400000},
      '{17200000, 34400000, 51600000, 68800000, 103200000, 137600000,
        154900000, 172100000, 206500000, 229400000, 258100000, 286800000},
      '{36000000, 72100000, 108100000, 144100000, 216200000, 288200000,
        324300000, 360300000, 432400000, 480400000, 540400000, 600400000},
      '{72100000, 144100000, 216200000, 288200000, 432400000, 576500000,
        648500000, 720600000, 864700000, 960700000, 1080900000, 1201000000}
   };

   rate_set_type expected_rates [$];

   function automatic longint unsigned rate_numerator(input wmrc_pkg::code_rate_type cr);
      case (cr)
         wmrc_pkg::CR_1_2: return 1;
         wmrc_pkg::CR_2_3: return 2;
         wmrc_pkg::CR_3_4: return 3;
         wmrc_pkg::CR_5_6: return 5;
         default:          return 0;
      endcase
   endfunction

   function automatic longint unsigned rate_denominator(input wmrc_pkg::code_rate_type cr);
      case (cr)
         wmrc_pkg::CR_1_2: return 2;
         wmrc_pkg::CR_2_3: return 3;
         wmrc_pkg::CR_3_4: return 4;
         wmrc_pkg::CR_5_6: return 6;
         default:          return 1;
      endcase
   endfunction

   function automatic rate_set_type predict_rates(input logic [2:0] cls,
                                                  input logic [4:0] mcs,
                                                  input logic [2:0] lcr,
                                                  input logic [8:0] lcon,
                                                  input logic [7:0] width,
                                                  input logic       sgi,
                                                  input logic [2:0] nss_in);
      rate_set_type            res;
      wmrc_pkg::code_rate_type cr;
      wmrc_pkg::code_rate_type legacy_cr;
      longint unsigned         rate;
      longint unsigned         bits;
      longint unsigned         sym;
      longint unsigned         nsc;
      longint unsigned         num;
      longint unsigned         den;
      longint unsigned         nss;
      int                      m;
      int                      row;
      res.data_rate       = '0;
      res.phy_rate        = '0;
      res.reference_rate  = '0;
      res.status          = wmrc_pkg::ST_OK;
      res.reference_valid = 1'b0;
      cr   = wmrc_pkg::CR_UNDEF;
      rate = 0;
      nss  = (nss_in > MAX_STREAMS) ? MAX_STREAMS : nss_in;
      legacy_cr = (lcr > wmrc_pkg::CR_5_6) ? wmrc_pkg::CR_UNDEF
                                           : wmrc_pkg::code_rate_type'(lcr);
      bits = 0;
      for (int i = 1; i < 9; i++) begin
         if (lcon[i]) bits = i;
      end
      case (cls)
         wmrc_pkg::CLS_DSSS, wmrc_pkg::CLS_HR_DSSS: begin
            cr   = legacy_cr;
            rate = ((cls == wmrc_pkg::CLS_DSSS) ? 64'd1000000 : 64'd1375000) * bits;
         end
         wmrc_pkg::CLS_OFDM, wmrc_pkg::CLS_ERP_OFDM: begin
            cr  = legacy_cr;
            sym = (width == 8'd10) ? 125000 : (width == 8'd5) ? 62500 : 250000;
            if (cr == wmrc_pkg::CR_UNDEF || cr == wmrc_pkg::CR_5_6) begin
               res.status = wmrc_pkg::ST_BAD_RATE;
            end else begin
               den  = rate_denominator(cr);
               rate = (sym * 48 * bits * rate_numerator(cr) + den - 1) / den;
            end
         end
         wmrc_pkg::CLS_HT, wmrc_pkg::CLS_VHT: begin
            m = (cls == wmrc_pkg::CLS_HT) ? int'(mcs[2:0]) : int'(mcs);
            if (m > 9) begin
               res.status = wmrc_pkg::ST_BAD_RATE;
            end else begin
               nsc = (width == 8'd40) ? 108 : (width == 8'd80) ? 234 :
                     (width == 8'd160) ? 468 : 52;
               cr   = MCS_RATE[m];
               bits = MCS_BITS[m];
               num  = nsc * bits * rate_numerator(cr);
               den  = rate_denominator(cr);
               if (sgi) rate = (num * 10000000 + den * 36 - 1) / (den * 36);
               else     rate = (num * 250000 + den - 1) / den;
               case (bits)
                  1: res.reference_rate = (cr == wmrc_pkg::CR_1_2) ?
                                          26'd6000000 : 26'd9000000;
                  2: res.reference_rate = (cr == wmrc_pkg::CR_1_2) ?
                                          26'd12000000 : 26'd18000000;
                  4: res.reference_rate = (cr == wmrc_pkg::CR_1_2) ?
                                          26'd24000000 : 26'd36000000;
                  6: res.reference_rate = (cr == wmrc_pkg::CR_1_2 ||
                                           cr == wmrc_pkg::CR_2_3) ?
                                          26'd48000000 : 26'd54000000;
                  default: res.reference_rate = 26'd54000000;
               endcase
               res.reference_valid = 1'b1;
            end
         end
         wmrc_pkg::CLS_HE: begin
            case (width)
               8'd2:    row = 0;
               8'd4:    row = 1;
               8'd8:    row = 2;
               8'd20:   row = 3;
               8'd40:   row = 4;
               8'd80:   row = 5;
               8'd160:  row = 6;
               default: row = -1;
            endcase
            if (mcs > 5'd11) begin
               res.status = wmrc_pkg::ST_BAD_RATE;
            end else begin
               cr = MCS_RATE[mcs];
               if (row < 0) res.status = wmrc_pkg::ST_NO_ENTRY;
               else if (HE_PER_STREAM[row][mcs] == 0) res.status = wmrc_pkg::ST_NO_ENTRY;
               else rate = HE_PER_STREAM[row][mcs];
            end
         end
         default: res.status = wmrc_pkg::ST_BAD_CLASS;
      endcase
      if (res.status != wmrc_pkg::ST_OK) begin
         res.reference_rate  = '0;
         res.reference_valid = 1'b0;
      end else begin
         rate = (rate * nss) & MASK33;
         res.data_rate = rate[32:0];
         if (cr == wmrc_pkg::CR_UNDEF) res.phy_rate = rate[32:0];
         else res.phy_rate = 33'(((rate * rate_denominator(cr)) /
                                  rate_numerator(cr)) & MASK33);
      end
      return res;
   endfunction

   task automatic check_field(input string name, input longint unsigned want,
                              input longint unsigned got);
      if (want != got) begin
         $display("%0t: result %0d %s mismatch: expected %0d, actual %0d",
                  $time, result_count, name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      rate_set_type want;
      if (!reset) begin
         // Retire the response before queuing this edge's request
         if (rsp_tvalid && rsp_tready) begin
            if (expected_rates.size() == 0) begin
               $display("%0t: unexpected response: expected none, actual data_rate %0d",
                        $time, rsp_tdata[32:0]);
               error_count++;
            end else begin
               want = expected_rates.pop_front();
               check_field("data_rate", want.data_rate, rsp_tdata[32:0]);
               check_field("phy_rate", want.phy_rate, rsp_tdata[65:33]);
               check_field("reference_rate", want.reference_rate, rsp_tdata[91:66]);
               check_field("status", want.status, rsp_tuser[1:0]);
               check_field("reference_valid", want.reference_valid, rsp_tuser[2]);
            end
            result_count++;
         end
         if (req_tvalid && req_tready) begin
            expected_rates.insert(expected_rates.size(),
                                  predict_rates(req_tuser, req_tdata[4:0],
                                                req_tdata[7:5], req_tdata[16:8],
                                                req_tdata[24:17], req_tdata[25],
                                                req_tdata[28:26]));
         end
      end
      pending_count <= expected_rates.size();
   end

endmodule

>>> sim/wifi_mcs_rate_calculator_top_tb.sv
// ---------------------------------------------------------------------------
// wifi_mcs_rate_calculator_top_tb: rate calculator testbench
// Sends directed corner requests for every modulation class, then random
// requests with random gaps and output stalls, including one long stall
// that backs the pipeline up. The checker predicts and compares results.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module wifi_mcs_rate_calculator_top_tb;

   localparam int MAX_STREAMS     = 4;
   localparam int RESET_CYCLES    = 8;
   localparam int RANDOM_ITEMS    = 1100;
   localparam int CALM_ITEMS      = 150;
   localparam int PRESSURE_AT     = 300;
   localparam int PRESSURE_CYCLES = 300;
   localparam int DRAIN_CYCLES    = 20;
   localparam int CYCLE_LIMIT     = 200000;

   localparam logic [2:0] CLS_UNKNOWN = 3'd7;
   localparam logic [2:0] CR_SPARE    = 3'd6;
   localparam logic [2:0] CR_RESERVED = 3'd7;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;
   logic [2:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [95:0] rsp_tdata;
   logic [2:0]  rsp_tuser;

   int   error_count;
   int   pending_count;
   int   result_count;
   int   sent_count;
   int   directed_count;
   int   cycle_count;
   bit   calm;
   bit   pressure_done;

   logic [2:0] cls;
   logic [4:0] mcs;
   logic [2:0] lcr;
   logic [8:0] lcon;
   logic [7:0] width;
   logic       sgi;
   logic [2:0] nss;
   int         gap_odds;

   wifi_mcs_rate_calculator_top #(
      .MAX_STREAMS(MAX_STREAMS)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   wifi_mcs_rate_calculator_checker #(
      .MAX_STREAMS(MAX_STREAMS)
   ) i_checker (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser),
      .error_count  (error_count),
      .pending_count(pending_count),
      .result_count (result_count)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d results outstanding",
                  cycle_count, pending_count);
         $display("FAIL wifi_mcs_rate_calculator_top");
         $finish;
      end
   end

   // Offer one request and hold it until accepted
   task automatic send_request(input logic [2:0] c, input logic [4:0] m,
                               input logic [2:0] r, input logic [8:0] con,
                               input logic [7:0] w, input logic g,
                               input logic [2:0] n);
      req_tvalid <= 1'b1;
      req_tuser  <= c;
      req_tdata  <= {3'b000, n, g, w, con, r, m};
      do @(posedge clock); while (!req_tready);
      sent_count++;
   endtask

   // Response side: random stalls, one long hold-off, none at the end
   initial begin
      rsp_tready <= 1'b0;
      @(posedge clock);
      forever begin
         if (!pressure_done && sent_count >= PRESSURE_AT) begin
            rsp_tready <= 1'b0;
            repeat (PRESSURE_CYCLES) @(posedge clock);
            pressure_done = 1'b1;
         end else if (calm) begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end else if ($urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge clock);
         end
      end
   end

   initial begin
      sent_count    = 0;
      calm          = 1'b0;
      gap_odds      = 0;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= '0;
      reset      <= 1'b1;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed corners
      send_request(wmrc_pkg::CLS_DSSS, 5'd0, wmrc_pkg::CR_UNDEF, 9'd4, 8'd20, 1'b0, 3'd1);
      send_request(wmrc_pkg::CLS_HR_DSSS, 5'd31, wmrc_pkg::CR_1_2, 9'd256, 8'd255, 1'b1,
                   3'd4);
      send_request(wmrc_pkg::CLS_DSSS, 5'd0, wmrc_pkg::CR_3_4, 9'd0, 8'd0, 1'b0, 3'd2);
      send_request(wmrc_pkg::CLS_HR_DSSS, 5'd0, wmrc_pkg::CR_2_3, 9'd1, 8'd0, 1'b0, 3'd3);
      send_request(wmrc_pkg::CLS_DSSS, 5'd0, CR_RESERVED, 9'd511, 8'd20, 1'b0, 3'd1);
      send_request(wmrc_pkg::CLS_OFDM, 5'd0, wmrc_pkg::CR_UNDEF, 9'd64, 8'd20, 1'b0, 3'd1);
      send_request(wmrc_pkg::CLS_ERP_OFDM, 5'd0, wmrc_pkg::CR_5_6, 9'd64, 8'd20, 1'b0,
                   3'd1);
      send_request(wmrc_pkg::CLS_OFDM, 5'd0, CR_SPARE, 9'd16, 8'd20, 1'b0, 3'd1);
      send_request(wmrc_pkg::CLS_OFDM, 5'd0, wmrc_pkg::CR_1_2, 9'd64, 8'd5, 1'b0, 3'd1);
      send_request(wmrc_pkg::CLS_ERP_OFDM, 5'd0, wmrc_pkg::CR_3_4, 9'd64, 8'd10, 1'b0,
                   3'd4);
      send_request(wmrc_pkg::CLS_OFDM, 5'd0, wmrc_pkg::CR_2_3, 9'd3, 8'd255, 1'b1, 3'd2);
      send_request(wmrc_pkg::CLS_HT, 5'd31, wmrc_pkg::CR_UNDEF, 9'd0, 8'd40, 1'b1, 3'd4);
      send_request(wmrc_pkg::CLS_HT, 5'd0, wmrc_pkg::CR_UNDEF, 9'd0, 8'd0, 1'b0, 3'd1);
      send_request(wmrc_pkg::CLS_VHT, 5'd9, wmrc_pkg::CR_UNDEF, 9'd0, 8'd160, 1'b1, 3'd4);
      send_request(wmrc_pkg::CLS_VHT, 5'd10, wmrc_pkg::CR_UNDEF, 9'd0, 8'd80, 1'b0, 3'd1);
      send_request(wmrc_pkg::CLS_VHT, 5'd31, wmrc_pkg::CR_UNDEF, 9'd0, 8'd20, 1'b1, 3'd2);
      send_request(wmrc_pkg::CLS_VHT, 5'd5, wmrc_pkg::CR_UNDEF, 9'd0, 8'd80, 1'b0, 3'd0);
      send_request(wmrc_pkg::CLS_VHT, 5'd7, wmrc_pkg::CR_UNDEF, 9'd0, 8'd40, 1'b0, 3'd7);
      send_request(wmrc_pkg::CLS_HE, 5'd11, wmrc_pkg::CR_UNDEF, 9'd0, 8'd160, 1'b0, 3'd4);
      send_request(wmrc_pkg::CLS_HE, 5'd10, wmrc_pkg::CR_UNDEF, 9'd0, 8'd2, 1'b0, 3'd1);
      send_request(wmrc_pkg::CLS_HE, 5'd3, wmrc_pkg::CR_UNDEF, 9'd0, 8'd3, 1'b0, 3'd1);
      send_request(wmrc_pkg::CLS_HE, 5'd12, wmrc_pkg::CR_UNDEF, 9'd0, 8'd20, 1'b0, 3'd1);
      send_request(wmrc_pkg::CLS_HE, 5'd0, wmrc_pkg::CR_UNDEF, 9'd0, 8'd8, 1'b1, 3'd1);
      send_request(wmrc_pkg::CLS_HE, 5'd10, wmrc_pkg::CR_UNDEF, 9'd0, 8'd20, 1'b0, 3'd3);
      send_request(CLS_UNKNOWN, 5'd31, CR_RESERVED, 9'd511, 8'd255, 1'b1, 3'd7);
      send_request(wmrc_pkg::CLS_DSSS, 5'd0, wmrc_pkg::CR_UNDEF, 9'd0, 8'd0, 1'b0, 3'd0);
      directed_count = sent_count;

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 64 == 0) gap_odds = $urandom_range(0, 2);
         calm = (i >= RANDOM_ITEMS - CALM_ITEMS);
         if (!calm && gap_odds != 0 && $urandom_range(0, 5) < gap_odds) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end
         case ($urandom_range(0, 99)) inside
            [0:3]:   cls = CLS_UNKNOWN;
            [4:33]:  cls = 3'($urandom_range(0, 3));
            default: cls = 3'($urandom_range(4, 6));
         endcase
         mcs  = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
                                            : 5'($urandom_range(0, 11));
         lcr  = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7))
                                            : 3'($urandom_range(1, 3));
         lcon = ($urandom_range(0, 3) == 0) ? 9'($urandom_range(0, 511))
                                            : 9'(1 << $urandom_range(0, 8));
         if ($urandom_range(0, 4) == 0) begin
            width = 8'($urandom_range(0, 255));
         end else begin
            case ($urandom_range(0, 8))
               0:       width = 8'd2;
               1:       width = 8'd4;
               2:       width = 8'd5;
               3:       width = 8'd8;
               4:       width = 8'd10;
               5:       width = 8'd20;
               6:       width = 8'd40;
               7:       width = 8'd80;
               default: width = 8'd160;
            endcase
         end
         sgi = 1'($urandom_range(0, 1));
         nss = ($urandom_range(0, 5) == 0) ? 3'($urandom_range(0, 7))
                                           : 3'($urandom_range(1, 4));
         send_request(cls, mcs, lcr, lcon, width, sgi, nss);
      end
      req_tvalid <= 1'b0;

      // Drain the pipeline, then wait on for any stragglers
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d rate requests (%0d directed) over all classes, %0d results checked,",
               sent_count, directed_count, result_count);
      $display("with random gaps, output stalls and one %0d-cycle output hold-off.",
               PRESSURE_CYCLES);
      if (error_count == 0 && pending_count == 0) begin
         $display("PASS wifi_mcs_rate_calculator_top");
      end else begin
         $display("FAIL wifi_mcs_rate_calculator_top");
      end
      $finish;
   end

endmodule

>>> wifi_mcs_rate_calculator_top.f
hdl/wmrc_pkg.sv
hdl/wifi_mcs_rate_calculator_top.sv
hdl/wmrc_checker.sv
sim/wifi_mcs_rate_calculator_checker.sv
sim/wifi_mcs_rate_calculator_top_tb.sv
